// ===== hdl/bpc_pkg.sv =====
// ----------------------------------------------------------------------------
// bpc_pkg
// shared types, register map and reset values of the button press classifier
// ----------------------------------------------------------------------------
`default_nettype none

package bpc_pkg;

    localparam int BPC_COUNT_BITS = 8;
    localparam int BPC_THR_BITS   = 8;
    localparam int BPC_ADDR_BITS  = 4;
    localparam int BPC_DATA_BITS  = 32;

    localparam logic [BPC_THR_BITS-1:0] RST_PRESS_CONFIRM   = 8'd5;
    localparam logic [BPC_THR_BITS-1:0] RST_LONG_PRESS      = 8'd50;
    localparam logic [BPC_THR_BITS-1:0] RST_MAX_HOLD        = 8'd150;
    localparam logic [BPC_THR_BITS-1:0] RST_RELEASE_CONFIRM = 8'd5;

    typedef enum logic [1:0] {
        CLASS_NONE  = 2'd0,
        CLASS_SHORT = 2'd1,
        CLASS_LONG  = 2'd2
    } t_press_class;

    typedef enum logic [1:0] {
        REG_PRESS_CONFIRM   = 2'd0,
        REG_LONG_PRESS      = 2'd1,
        REG_MAX_HOLD        = 2'd2,
        REG_RELEASE_CONFIRM = 2'd3
    } t_reg_idx;

    typedef enum logic {
        KIND_TICK   = 1'b0,
        KIND_REINIT = 1'b1
    } t_kind;

    typedef struct packed {
        logic [BPC_THR_BITS-1:0] press_confirm_ticks;
        logic [BPC_THR_BITS-1:0] long_press_ticks;
        logic [BPC_THR_BITS-1:0] max_hold_ticks;
        logic [BPC_THR_BITS-1:0] release_confirm_ticks;
    } t_cfg;

endpackage

`default_nettype wire

// ===== hdl/bpc_in_if.sv =====
// ----------------------------------------------------------------------------
// bpc_in_if
// sample request channel: tick or reinitialise, with the raw pin level
// ----------------------------------------------------------------------------
`default_nettype none

interface bpc_in_if;

    logic valid;
    logic ready;
    logic kind;
    logic pin_level;

    modport source (output valid, output kind, output pin_level, input ready);
    modport sink   (input valid, input kind, input pin_level, output ready);

endinterface

`default_nettype wire

// ===== hdl/bpc_out_if.sv =====
// ----------------------------------------------------------------------------
// bpc_out_if
// result request channel: press class and confirmed flag
// ----------------------------------------------------------------------------
`default_nettype none

interface bpc_out_if;

    logic       valid;
    logic       ready;
    logic [1:0] press_class;
    logic       press_confirmed;

    modport source (output valid, output press_class, output press_confirmed, input ready);
    modport sink   (input valid, input press_class, input press_confirmed, output ready);

endinterface

`default_nettype wire

// ===== hdl/bpc_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// bpc_cfg_regs
// apb register file holding the four tick thresholds
// ----------------------------------------------------------------------------
`default_nettype none

module bpc_cfg_regs
    import bpc_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     psel,
    input  wire logic                     penable,
    input  wire logic                     pwrite,
    input  wire logic [BPC_ADDR_BITS-1:0] paddr,
    input  wire logic [BPC_DATA_BITS-1:0] pwdata,
    output      logic [BPC_DATA_BITS-1:0] prdata,
    output      logic                     pready,
    output      t_cfg                     o_cfg
);

    t_cfg     r_cfg;
    t_cfg     n_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign w_idx  = t_reg_idx'(paddr[3:2]);
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (w_wr) begin
            unique case (w_idx)
                REG_PRESS_CONFIRM:   n_cfg.press_confirm_ticks   = pwdata[BPC_THR_BITS-1:0];
                REG_LONG_PRESS:      n_cfg.long_press_ticks      = pwdata[BPC_THR_BITS-1:0];
                REG_MAX_HOLD:        n_cfg.max_hold_ticks        = pwdata[BPC_THR_BITS-1:0];
                REG_RELEASE_CONFIRM: n_cfg.release_confirm_ticks = pwdata[BPC_THR_BITS-1:0];
                default:             n_cfg = r_cfg;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_PRESS_CONFIRM:   prdata = BPC_DATA_BITS'(r_cfg.press_confirm_ticks);
            REG_LONG_PRESS:      prdata = BPC_DATA_BITS'(r_cfg.long_press_ticks);
            REG_MAX_HOLD:        prdata = BPC_DATA_BITS'(r_cfg.max_hold_ticks);
            REG_RELEASE_CONFIRM: prdata = BPC_DATA_BITS'(r_cfg.release_confirm_ticks);
            default:             prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.press_confirm_ticks   <= RST_PRESS_CONFIRM;
            r_cfg.long_press_ticks      <= RST_LONG_PRESS;
            r_cfg.max_hold_ticks        <= RST_MAX_HOLD;
            r_cfg.release_confirm_ticks <= RST_RELEASE_CONFIRM;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/button_press_classifier_core.sv =====
// result: registered, and raised in the cycle after an accepted sample request
// throughput: one sample per cycle if not stalled, set by the single pass
//   through the counter and flag update between state and result register
// reset: synchronous active low; clears state, result valid and loads the
//   default thresholds
// ----------------------------------------------------------------------------
// button_press_classifier_core
// debounces an active-low button and classifies presses as short or long
// ----------------------------------------------------------------------------
`default_nettype none

module button_press_classifier_core
    import bpc_pkg::*;
#(
    parameter int COUNT_BITS = BPC_COUNT_BITS
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    bpc_in_if.sink                        i_in,
    bpc_out_if.source                     o_out,
    input  wire logic                     psel,
    input  wire logic                     penable,
    input  wire logic                     pwrite,
    input  wire logic [BPC_ADDR_BITS-1:0] paddr,
    input  wire logic [BPC_DATA_BITS-1:0] pwdata,
    output      logic [BPC_DATA_BITS-1:0] prdata,
    output      logic                     pready
);

    localparam int CMP_BITS = (COUNT_BITS > BPC_THR_BITS) ? COUNT_BITS : BPC_THR_BITS;
    localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

    t_cfg w_cfg;

    bpc_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    logic                  r_last_pressed, n_last_pressed;
    logic [COUNT_BITS-1:0] r_held, n_held;
    logic [COUNT_BITS-1:0] r_rel, n_rel;
    t_press_class          r_verdict, n_verdict;
    logic                  r_push_seen, n_push_seen;
    logic                  r_rel_once, n_rel_once;

    logic                  r_out_valid;
    t_press_class          r_out_class;
    logic                  r_out_confirmed;

    logic                  w_fire;
    logic                  w_pressed;
    logic [COUNT_BITS-1:0] w_held_inc;
    logic [COUNT_BITS-1:0] w_rel_inc;

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign w_fire     = i_in.valid && i_in.ready;
    assign w_pressed  = ~i_in.pin_level;
    assign w_held_inc = (r_held == CNT_MAX) ? r_held : r_held + 1'b1;
    assign w_rel_inc  = (r_rel == CNT_MAX) ? r_rel : r_rel + 1'b1;

    always_comb begin
        n_last_pressed = r_last_pressed;
        n_held         = r_held;
        n_rel          = r_rel;
        n_verdict      = r_verdict;
        n_push_seen    = r_push_seen;
        n_rel_once     = r_rel_once;
        if (t_kind'(i_in.kind) == KIND_REINIT) begin
            n_last_pressed = w_pressed;
            n_held         = '0;
            n_rel          = '0;
            n_verdict      = CLASS_NONE;
            n_push_seen    = 1'b0;
            n_rel_once     = 1'b0;
        end else if (!r_push_seen) begin
            if (w_pressed != r_last_pressed) begin
                n_held         = '0;
                n_last_pressed = w_pressed;
            end else if (r_last_pressed) begin
                n_held = w_held_inc;
                if (CMP_BITS'(w_held_inc) > CMP_BITS'(w_cfg.press_confirm_ticks)) begin
                    n_push_seen = 1'b1;
                end
            end
        end else begin
            if (w_pressed != r_last_pressed) begin
                n_rel          = '0;
                n_last_pressed = w_pressed;
                n_rel_once     = 1'b1;
            end else if (r_last_pressed) begin
                if (!r_rel_once) begin
                    n_held = w_held_inc;
                    if (r_verdict == CLASS_NONE &&
                        CMP_BITS'(w_held_inc) >= CMP_BITS'(w_cfg.max_hold_ticks)) begin
                        n_verdict = CLASS_LONG;
                    end
                end
            end else begin
                n_rel = w_rel_inc;
                if (r_verdict == CLASS_NONE &&
                    CMP_BITS'(w_rel_inc) > CMP_BITS'(w_cfg.release_confirm_ticks)) begin
                    n_verdict = (CMP_BITS'(r_held) >= CMP_BITS'(w_cfg.long_press_ticks))
                                ? CLASS_LONG : CLASS_SHORT;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_pressed <= 1'b0;
            r_held         <= '0;
            r_rel          <= '0;
            r_verdict      <= CLASS_NONE;
            r_push_seen    <= 1'b0;
            r_rel_once     <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            if (w_fire) begin
                r_last_pressed <= n_last_pressed;
                r_held         <= n_held;
                r_rel          <= n_rel;
                r_verdict      <= n_verdict;
                r_push_seen    <= n_push_seen;
                r_rel_once     <= n_rel_once;
                r_out_valid    <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid    <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out_class     <= n_verdict;
            r_out_confirmed <= n_push_seen;
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.press_class     = r_out_class;
    assign o_out.press_confirmed = r_out_confirmed;

`ifndef NO_ASSERTIONS
    a_verdict_needs_push : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_verdict != CLASS_NONE |-> r_push_seen)
        else $error("verdict set without a confirmed push");

    a_release_needs_push : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rel_once |-> r_push_seen)
        else $error("release flagged without a confirmed push");

    a_verdict_sticky : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire && r_verdict != CLASS_NONE && t_kind'(i_in.kind) == KIND_TICK
        |=> $stable(r_verdict))
        else $error("verdict changed without reinitialise");

    a_reinit_result : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire && t_kind'(i_in.kind) == KIND_REINIT
        |=> r_out_valid && r_out_class == CLASS_NONE && !r_out_confirmed)
        else $error("reinitialise result not cleared");
`endif

endmodule

`default_nettype wire
